[rtl/drf_pkg.sv]
package drf_pkg;

  // Field widths fixed by the command format.
  localparam int CoordW = 10;
  localparam int ChanW  = 8;
  localparam int PixW   = 16;

  // Default frame size.
  localparam int DefFrameWidth  = 320;
  localparam int DefFrameHeight = 240;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_FILL  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SWAP  = 2'd2,
    REQ_READ  = 2'd3
  } req_code_t;

  // One command beat.
  typedef struct packed {
    logic [1:0]        req_type;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] rect_width;
    logic [CoordW-1:0] rect_height;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } drf_req_t;

  // One result beat.
  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            pixel_in_frame;
    logic            front_is_second;
  } drf_rsp_t;

  // Pack 8-bit channels to RGB565 by dropping the low bits.
  function automatic logic [PixW-1:0] pack565(input logic [ChanW-1:0] r,
                                              input logic [ChanW-1:0] g,
                                              input logic [ChanW-1:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[rtl/drf_frame_mem.sv]
module drf_frame_mem #(
  parameter int Depth = 2 * drf_pkg::DefFrameWidth * drf_pkg::DefFrameHeight,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AddrW-1:0]        waddr,
  input  logic [drf_pkg::PixW-1:0] wdata,
  input  logic                    re,
  input  logic [AddrW-1:0]        raddr,
  output logic [drf_pkg::PixW-1:0] rdata
);
  import drf_pkg::*;

  logic [PixW-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/double_buffered_rect_fill.sv]
// Channel   Direction  Handshake           Payload
// command   in         start, busy         req (drf_req_t)
// result    out        done (one cycle)    rsp (drf_rsp_t)
//
// Swap: the result is strobed in the cycle after the command beat.
// Read: setup forms row times frame width; the address then feeds the registered memory read.
// Fill and clear: one pixel written per cycle through the single memory write port, row by row
// over the clipped rectangle; a clear covers the whole frame.
// Reset (rst, synchronous) puts the first buffer in front; frame contents stay undefined.
// busy is high from the cycle after an accepted non-swap beat until the result is strobed;
// the receiver cannot stall, so each result is shown for exactly one cycle.
module double_buffered_rect_fill #(
  parameter int FRAME_WIDTH  = drf_pkg::DefFrameWidth,
  parameter int FRAME_HEIGHT = drf_pkg::DefFrameHeight
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  drf_pkg::drf_req_t req,
  output logic              done,
  output drf_pkg::drf_rsp_t rsp
);
  import drf_pkg::*;

  localparam int PixPerBuf = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int Depth     = 2 * PixPerBuf;
  localparam int AddrW     = $clog2(Depth);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SETUP    = 6'b000010,
    S_ADDR     = 6'b000100,
    S_FILL     = 6'b001000,
    S_RD_ISSUE = 6'b010000,
    S_RD_WAIT  = 6'b100000
  } state_t;

  state_t            state;
  drf_req_t          cmd;
  logic              front;
  logic [CoordW-1:0] x0, y0, x1, y1, x, y;
  logic [AddrW-1:0]  prod, addr, row_addr;
  logic [PixW-1:0]   color, rdata;
  logic              mem_re;

  // Setup terms: clip edges for fill and clear, frame check for read, start address.
  logic [CoordW-1:0] sx_v, sy_v, w_v, h_v, x1_v, y1_v;
  logic [CoordW:0]   x_end, y_end;
  logic              is_read, in_frame, empty;
  logic [AddrW-1:0]  base, start_addr;

  always_comb begin
    is_read = (cmd.req_type == REQ_READ);
    if (cmd.req_type == REQ_CLEAR) begin
      sx_v = '0;
      sy_v = '0;
      w_v  = CoordW'(FRAME_WIDTH);
      h_v  = CoordW'(FRAME_HEIGHT);
    end else begin
      sx_v = cmd.start_x;
      sy_v = cmd.start_y;
      w_v  = cmd.rect_width;
      h_v  = cmd.rect_height;
    end
    x_end = {1'b0, sx_v} + {1'b0, w_v};
    y_end = {1'b0, sy_v} + {1'b0, h_v};
    x1_v  = (x_end > (CoordW+1)'(FRAME_WIDTH)) ? CoordW'(FRAME_WIDTH) : x_end[CoordW-1:0];
    y1_v  = (y_end > (CoordW+1)'(FRAME_HEIGHT)) ? CoordW'(FRAME_HEIGHT) : y_end[CoordW-1:0];
    empty = (sx_v >= x1_v) || (sy_v >= y1_v);
    in_frame = (cmd.start_x < CoordW'(FRAME_WIDTH)) && (cmd.start_y < CoordW'(FRAME_HEIGHT));
    // Reads go to the front buffer, writes to the back buffer.
    base = ((is_read ? front : ~front)) ? AddrW'(PixPerBuf) : '0;
    start_addr = base + prod + AddrW'(x0);
  end

  // Sequencer: swaps in idle, clips in setup, then steps the address through the rectangle or reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= req;
            color <= pack565(req.red, req.green, req.blue);
            if (req.req_type == REQ_SWAP) begin
              front <= ~front;
              done  <= 1'b1;
              rsp   <= '{pixel_value: '0, pixel_in_frame: 1'b0, front_is_second: ~front};
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          x0   <= sx_v;
          y0   <= sy_v;
          x1   <= x1_v;
          y1   <= y1_v;
          prod <= AddrW'(sy_v) * AddrW'(FRAME_WIDTH);
          if ((is_read && !in_frame) || (!is_read && empty)) begin
            done  <= 1'b1;
            rsp   <= '{pixel_value: '0, pixel_in_frame: 1'b0, front_is_second: front};
            state <= S_IDLE;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr     <= start_addr;
          row_addr <= start_addr;
          x        <= x0;
          y        <= y0;
          state    <= is_read ? S_RD_ISSUE : S_FILL;
        end
        S_FILL: begin
          if (x == x1 - CoordW'(1)) begin
            if (y == y1 - CoordW'(1)) begin
              done  <= 1'b1;
              rsp   <= '{pixel_value: '0, pixel_in_frame: 1'b0, front_is_second: front};
              state <= S_IDLE;
            end else begin
              x        <= x0;
              y        <= y + CoordW'(1);
              row_addr <= row_addr + AddrW'(FRAME_WIDTH);
              addr     <= row_addr + AddrW'(FRAME_WIDTH);
            end
          end else begin
            x    <= x + CoordW'(1);
            addr <= addr + AddrW'(1);
          end
        end
        S_RD_ISSUE: begin
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          done  <= 1'b1;
          rsp   <= '{pixel_value: rdata, pixel_in_frame: 1'b1, front_is_second: front};
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state != S_IDLE);
  assign mem_re = (state == S_RD_ISSUE);

  drf_frame_mem #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_mem (
    .clk  (clk),
    .we   (state == S_FILL),
    .waddr(addr),
    .wdata(color),
    .re   (mem_re),
    .raddr(addr),
    .rdata(rdata)
  );

  // A result is only strobed once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while sequencer busy");

  // The pixel walk never leaves the clipped rectangle.
  a_fill_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (x < x1) && (y < y1) && (x >= x0) && (y >= y0))
    else $error("fill walk outside clipped rectangle");

  // Only an in-frame read returns a nonzero pixel.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.pixel_in_frame) |-> (rsp.pixel_value == '0))
    else $error("nonzero pixel on a result with no in-frame read");

  // A swap beat answers in the next cycle with the toggled buffer.
  a_swap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type == REQ_SWAP)) |=> done && (rsp.front_is_second == front))
    else $error("swap result missing or wrong");

endmodule
